// ===== src/fdc_pkg.sv =====
// shared constants and types for the frame deframer with crc-16 trailer
package fdc_pkg;

  // header layout: sync, sync, command, address, length, sum8
  localparam int unsigned HdrBytes = 6;
  localparam int unsigned FillW    = $clog2(HdrBytes + 1);

  // longest payload a header may announce
  localparam logic [7:0] MaxPayload = 8'd128;

  // crc-16/modbus seed and reflected polynomial
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // command from the sequencer to the shared crc unit
  typedef struct packed {
    logic       init;
    logic       feed;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

// ===== src/fdc_crc_unit.sv =====
// shared crc-16/modbus unit, one byte folded into the running crc per cycle
module fdc_crc_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fdc_pkg::crc_ctrl_t    ctrl,
  output logic [15:0]           crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  // bytewise reflected crc step, eight shift stages
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ fdc_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // next crc: reseed, fold one byte, or hold
  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.init) begin
      crc_nxt = fdc_pkg::CrcInit;
    end else if (ctrl.feed) begin
      crc_nxt = crc_byte(crc_r, ctrl.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= fdc_pkg::CrcInit;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

// ===== src/frame_deframer_crc16.sv =====
// frame deframer top: header hunt, payload pass-through, crc-16 trailer check
//
// Input channel in_*: one received byte per item (in_rx_byte), valid/stall.
// Output channel out_*: one result per payload byte (kind 0, data in
// out_data_byte) and one frame end report (kind 1, last 1, status 0 ok or
// 1 crc mismatch), each carrying the header's address and length.
// Configuration: apb-style writes to sync_first (0x0), sync_second (0x4)
// and wanted_command (0x8); pready is always high, reads return the value.
// A hunt byte, payload byte or crc byte is taken without a pause; the byte
// that completes a valid header stalls the input while the shared crc
// unit folds the six header bytes one per cycle before the next item.
// A result appears in the output register the cycle after its byte.
// When the receiver stalls, the result holds in the output register and
// the input stalls for as long as that result waits, whatever the phase.
// Reset (synchronous, rst_n low) empties the window, returns to hunting,
// seeds the crc with 0xFFFF and restores the register reset values.
module frame_deframer_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_frame_status,
  output logic [7:0]  out_frame_address,
  output logic [7:0]  out_payload_length,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned HdrBytes = fdc_pkg::HdrBytes;
  localparam int unsigned FillW    = fdc_pkg::FillW;
  localparam int unsigned CntW     = $clog2(HdrBytes);

  // register indexes on paddr[3:2]
  localparam logic [1:0] RegSyncFirst  = 2'd0;
  localparam logic [1:0] RegSyncSecond = 2'd1;
  localparam logic [1:0] RegCommand    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_HDR
  } state_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // configuration registers
  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic [7:0] command_r;
  logic       cfg_wr;

  // sequencer and frame state
  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       win_r   [HdrBytes];
  logic [7:0]       win_nxt [HdrBytes];
  logic [7:0]       win_in  [HdrBytes];
  logic [FillW-1:0] fill_r, fill_nxt;
  logic [CntW-1:0]  hcnt_r, hcnt_nxt;
  logic [7:0]       remain_r, remain_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_status_r, out_status_nxt;

  logic                in_accept;
  logic                out_take;
  logic [7:0]          hdr_sum;
  logic                hdr_match;
  logic [15:0]         crc;
  fdc_pkg::crc_ctrl_t  crc_ctrl;

  // handshakes
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  // window after shifting in the incoming byte
  always_comb begin
    for (int i = 0; i < HdrBytes - 1; i++) begin
      win_in[i] = win_r[i+1];
    end
    win_in[HdrBytes-1] = in_rx_byte;
  end

  // header check on the shifted window
  assign hdr_sum   = win_in[0] + win_in[1] + win_in[2] + win_in[3] + win_in[4];
  assign hdr_match = (win_in[0] == sync_first_r) && (win_in[1] == sync_second_r) &&
                     (win_in[2] == command_r) && (win_in[5] == hdr_sum) &&
                     (win_in[4] <= fdc_pkg::MaxPayload);

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    hcnt_nxt       = hcnt_r;
    remain_nxt     = remain_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    crc_lo_nxt     = crc_lo_r;
    out_valid_nxt  = out_valid_r && !out_take;
    out_kind_nxt   = out_kind_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    crc_ctrl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (phase_r)
            PH_HUNT: begin
              win_nxt = win_in;
              if (fill_r != FillW'(HdrBytes)) begin
                fill_nxt = fill_r + FillW'(1);
              end
              if ((fill_r >= FillW'(HdrBytes - 1)) && hdr_match) begin
                addr_nxt      = win_in[3];
                len_nxt       = win_in[4];
                remain_nxt    = win_in[4];
                fill_nxt      = '0;
                hcnt_nxt      = '0;
                crc_ctrl.init = 1'b1;
                state_nxt     = ST_HDR;
              end
            end
            PH_PAYLOAD: begin
              crc_ctrl.feed  = 1'b1;
              crc_ctrl.data  = in_rx_byte;
              remain_nxt     = remain_r - 8'd1;
              if (remain_r == 8'd1) begin
                phase_nxt = PH_CRC_LO;
              end
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = 1'b0;
              out_data_nxt   = in_rx_byte;
              out_status_nxt = 1'b0;
            end
            PH_CRC_LO: begin
              crc_lo_nxt = in_rx_byte;
              phase_nxt  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = 1'b1;
              out_data_nxt   = 8'd0;
              out_status_nxt = ({in_rx_byte, crc_lo_r} != crc);
              phase_nxt      = PH_HUNT;
              fill_nxt       = '0;
              remain_nxt     = 8'd0;
              crc_ctrl.init  = 1'b1;
            end
            default: begin
              phase_nxt = PH_HUNT;
            end
          endcase
        end
      end
      ST_HDR: begin
        // fold the oldest header byte, rotate the window
        crc_ctrl.feed = 1'b1;
        crc_ctrl.data = win_r[0];
        for (int i = 0; i < HdrBytes - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[HdrBytes-1] = win_r[0];
        hcnt_nxt = hcnt_r + CntW'(1);
        if (hcnt_r == CntW'(HdrBytes - 1)) begin
          state_nxt = ST_IDLE;
          phase_nxt = (len_r != 8'd0) ? PH_PAYLOAD : PH_CRC_LO;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HUNT;
      fill_r      <= '0;
      hcnt_r      <= '0;
      remain_r    <= 8'd0;
      addr_r      <= 8'd0;
      len_r       <= 8'd0;
      crc_lo_r    <= 8'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HdrBytes; i++) begin
        win_r[i] <= 8'd0;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      hcnt_r      <= hcnt_nxt;
      remain_r    <= remain_nxt;
      addr_r      <= addr_nxt;
      len_r       <= len_nxt;
      crc_lo_r    <= crc_lo_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // shared crc unit
  fdc_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .crc   (crc)
  );

  // configuration writes
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'hAA;
      sync_second_r <= 8'h55;
      command_r     <= 8'h00;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegSyncFirst:  sync_first_r  <= pwdata[7:0];
        RegSyncSecond: sync_second_r <= pwdata[7:0];
        RegCommand:    command_r     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[3:2])
      RegSyncFirst:  prdata = {24'd0, sync_first_r};
      RegSyncSecond: prdata = {24'd0, sync_second_r};
      RegCommand:    prdata = {24'd0, command_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // output ports
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_data_byte      = out_data_r;
  assign out_frame_status   = out_status_r;
  assign out_frame_address  = addr_r;
  assign out_payload_length = len_r;
  assign out_last           = out_kind_r;

endmodule
